[rtl/tmm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmm_pkg: shared types and constants of the tiled matrix multiply
// Store geometry, field widths, request codes, control state and the
// structs that run between the top level and the tile walker.
// ----------------------------------------------------------------------------
package tmm_pkg;

    // Store geometry
    localparam int MAX_N       = 32;
    localparam int TILE        = 4;
    localparam int STORE_WORDS = MAX_N * MAX_N;
    localparam int ADDR_W      = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
    // Loop counters hold a tile base plus one tile
    localparam int CNT_W       = $clog2(MAX_N + TILE + 1);

    // Field widths
    localparam int OP_W   = 2;
    localparam int ROW_W  = 5;
    localparam int COL_W  = 5;
    localparam int VAL_W  = 32;
    localparam int SIZE_W = 6;

    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(32);

    // Request codes
    typedef enum logic [OP_W-1:0] {
        OP_LOAD_A = 2'd0,
        OP_LOAD_B = 2'd1,
        OP_RUN    = 2'd2,
        OP_READ   = 2'd3
    } t_opcode;

    // Result kinds
    localparam logic RK_DONE = 1'b0;
    localparam logic RK_READ = 1'b1;

    // Control states
    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_CLEAR,
        S_ISSUE,
        S_MUL,
        S_ACC,
        S_DONE
    } t_state;

    // Walker control and position
    typedef struct packed {
        logic start;
        logic step;
    } t_walk_ctl;

    typedef struct packed {
        logic [CNT_W-1:0] i;
        logic [CNT_W-1:0] k;
        logic [CNT_W-1:0] j;
        logic             last;
    } t_walk_pos;

    // Row-major word address of one element
    function automatic logic [ADDR_W-1:0] cell_addr(input int unsigned row,
                                                    input int unsigned col);
        return ADDR_W'(row * MAX_N + col);
    endfunction

endpackage

[rtl/tmm_in_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmm_in_if: request channel
// Valid/ready channel carrying one load, run or read request.
// ----------------------------------------------------------------------------
interface tmm_in_if;
    import tmm_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [OP_W-1:0]         opcode;
    logic [ROW_W-1:0]        row_index;
    logic [COL_W-1:0]        col_index;
    logic signed [VAL_W-1:0] element_value;

    modport source (output valid, opcode, row_index, col_index, element_value,
                    input ready);
    modport sink   (input valid, opcode, row_index, col_index, element_value,
                    output ready);
endinterface

[rtl/tmm_out_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmm_out_if: result channel
// Valid/ready channel carrying a done notice or one element of C.
// ----------------------------------------------------------------------------
interface tmm_out_if;
    import tmm_pkg::*;

    logic                    valid;
    logic                    ready;
    logic                    result_kind;
    logic [ROW_W-1:0]        out_row;
    logic [COL_W-1:0]        out_col;
    logic signed [VAL_W-1:0] product_value;

    modport source (output valid, result_kind, out_row, out_col, product_value,
                    input ready);
    modport sink   (input valid, result_kind, out_row, out_col, product_value,
                    output ready);
endinterface

[rtl/tmm_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmm_ram: simple dual-port synchronous RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module tmm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/tmm_walk.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmm_walk: tiled loop walker
// Steps (i, k, j) in tile order ii, kk, jj then i, k, j, cutting edge
// tiles at n, and flags the last product of the run.
// ----------------------------------------------------------------------------
module tmm_walk (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  tmm_pkg::t_walk_ctl            i_ctl,
    input  logic [tmm_pkg::CNT_W-1:0]     i_n,
    output tmm_pkg::t_walk_pos            o_pos
);
    import tmm_pkg::*;

    localparam logic [CNT_W-1:0] TILE_C = CNT_W'(TILE);
    localparam logic [CNT_W-1:0] ONE_C  = CNT_W'(1);

    logic [CNT_W-1:0] r_n;
    logic [CNT_W-1:0] r_ii, r_kk, r_jj, r_i, r_k, r_j;
    logic [CNT_W-1:0] n_ii, n_kk, n_jj, n_i, n_k, n_j;
    logic [CNT_W-1:0] i_end, k_end, j_end;
    logic             i_wrap, k_wrap, j_wrap, ii_wrap, kk_wrap, jj_wrap;

    // Tile limits, cut at n
    always_comb begin
        i_end   = (r_ii + TILE_C > r_n) ? r_n : r_ii + TILE_C;
        k_end   = (r_kk + TILE_C > r_n) ? r_n : r_kk + TILE_C;
        j_end   = (r_jj + TILE_C > r_n) ? r_n : r_jj + TILE_C;
        j_wrap  = (r_j + ONE_C >= j_end);
        k_wrap  = (r_k + ONE_C >= k_end);
        i_wrap  = (r_i + ONE_C >= i_end);
        jj_wrap = (r_jj + TILE_C >= r_n);
        kk_wrap = (r_kk + TILE_C >= r_n);
        ii_wrap = (r_ii + TILE_C >= r_n);
    end

    // Next position: innermost loop first
    always_comb begin
        n_ii = r_ii;
        n_kk = r_kk;
        n_jj = r_jj;
        n_i  = r_i;
        n_k  = r_k;
        n_j  = r_j;
        if (!j_wrap) begin
            n_j = r_j + ONE_C;
        end else begin
            n_j = r_jj;
            if (!k_wrap) begin
                n_k = r_k + ONE_C;
            end else begin
                n_k = r_kk;
                if (!i_wrap) begin
                    n_i = r_i + ONE_C;
                end else if (!jj_wrap) begin
                    n_i  = r_ii;
                    n_jj = r_jj + TILE_C;
                    n_j  = r_jj + TILE_C;
                end else if (!kk_wrap) begin
                    n_i  = r_ii;
                    n_jj = '0;
                    n_j  = '0;
                    n_kk = r_kk + TILE_C;
                    n_k  = r_kk + TILE_C;
                end else begin
                    n_jj = '0;
                    n_j  = '0;
                    n_kk = '0;
                    n_k  = '0;
                    n_ii = r_ii + TILE_C;
                    n_i  = r_ii + TILE_C;
                end
            end
        end
    end

    // Counter registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n  <= '0;
            r_ii <= '0;
            r_kk <= '0;
            r_jj <= '0;
            r_i  <= '0;
            r_k  <= '0;
            r_j  <= '0;
        end else if (i_ctl.start) begin
            r_n  <= i_n;
            r_ii <= '0;
            r_kk <= '0;
            r_jj <= '0;
            r_i  <= '0;
            r_k  <= '0;
            r_j  <= '0;
        end else if (i_ctl.step) begin
            r_ii <= n_ii;
            r_kk <= n_kk;
            r_jj <= n_jj;
            r_i  <= n_i;
            r_k  <= n_k;
            r_j  <= n_j;
        end
    end

    assign o_pos.i    = r_i;
    assign o_pos.k    = r_k;
    assign o_pos.j    = r_j;
    assign o_pos.last = j_wrap && k_wrap && i_wrap && jj_wrap && kk_wrap && ii_wrap;

endmodule

[rtl/tiled_matrix_multiply.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tiled_matrix_multiply: square integer matrix multiply C = A x B
// A load request writes one element of A or B in the cycle it is taken and
// gives no result. A read request fetches one element of C through the
// registered read port of the C store and presents it from the output
// register once that is free. A run request first clears all of C, one word
// a cycle, then walks all n^3 products in tile order, each as read A, B and
// C; multiply; add and write C, then posts the done result. The run time is
// set by the read-modify-write of one C word per product, which is not
// overlapped with the next product. C reads as zero from reset until the
// first run has cleared it.
// New requests are taken whenever the controller is idle, also while a
// result waits in the output register. Size writes take effect at once.
// ----------------------------------------------------------------------------
module tiled_matrix_multiply (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_wr_en,
    input  logic [tmm_pkg::SIZE_W-1:0]   i_cfg_wr_data,
    tmm_in_if.sink                       i_in,
    tmm_out_if.source                    o_out
);
    import tmm_pkg::*;

    localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(STORE_WORDS - 1);

    t_state              r_state, n_state;
    logic [SIZE_W-1:0]   r_size;
    logic [CNT_W-1:0]    size_n;
    logic [ADDR_W-1:0]   r_clr;
    logic                r_c_blank;
    logic [VAL_W-1:0]    r_prod;
    logic [ROW_W-1:0]    r_rd_row;
    logic [COL_W-1:0]    r_rd_col;
    logic                r_rd_inside;

    logic                r_out_valid;
    logic                r_out_kind;
    logic [ROW_W-1:0]    r_out_row;
    logic [COL_W-1:0]    r_out_col;
    logic [VAL_W-1:0]    r_out_value;

    logic                accept;
    logic                in_inside;
    logic [ADDR_W-1:0]   in_addr;
    logic                out_free;
    logic                out_load;

    t_walk_ctl           walk_ctl;
    t_walk_pos           walk_pos;

    logic                a_wr_en, b_wr_en;
    logic                ab_rd_en;
    logic [VAL_W-1:0]    a_rd_data, b_rd_data;
    logic                c_wr_en;
    logic [ADDR_W-1:0]   c_wr_addr;
    logic [VAL_W-1:0]    c_wr_data;
    logic                c_rd_en;
    logic [ADDR_W-1:0]   c_rd_addr;
    logic [VAL_W-1:0]    c_rd_data;

    // Request decode
    assign accept    = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == S_IDLE);
    assign in_inside = (32'(i_in.row_index) < MAX_N) && (32'(i_in.col_index) < MAX_N);
    assign in_addr   = in_inside ? cell_addr(32'(i_in.row_index), 32'(i_in.col_index))
                                 : '0;
    assign a_wr_en   = accept && (i_in.opcode == OP_LOAD_A) && in_inside;
    assign b_wr_en   = accept && (i_in.opcode == OP_LOAD_B) && in_inside;

    // Saturate size at the store dimension
    assign size_n = (32'(r_size) > MAX_N) ? CNT_W'(MAX_N) : CNT_W'(r_size);

    assign out_free = !r_out_valid || o_out.ready;

    // Stores
    tmm_ram #(.WIDTH(VAL_W), .DEPTH(STORE_WORDS)) u_ram_a (
        .i_clk     (i_clk),
        .i_wr_en   (a_wr_en),
        .i_wr_addr (in_addr),
        .i_wr_data (i_in.element_value),
        .i_rd_en   (ab_rd_en),
        .i_rd_addr (cell_addr(32'(walk_pos.i), 32'(walk_pos.k))),
        .o_rd_data (a_rd_data)
    );

    tmm_ram #(.WIDTH(VAL_W), .DEPTH(STORE_WORDS)) u_ram_b (
        .i_clk     (i_clk),
        .i_wr_en   (b_wr_en),
        .i_wr_addr (in_addr),
        .i_wr_data (i_in.element_value),
        .i_rd_en   (ab_rd_en),
        .i_rd_addr (cell_addr(32'(walk_pos.k), 32'(walk_pos.j))),
        .o_rd_data (b_rd_data)
    );

    tmm_ram #(.WIDTH(VAL_W), .DEPTH(STORE_WORDS)) u_ram_c (
        .i_clk     (i_clk),
        .i_wr_en   (c_wr_en),
        .i_wr_addr (c_wr_addr),
        .i_wr_data (c_wr_data),
        .i_rd_en   (c_rd_en),
        .i_rd_addr (c_rd_addr),
        .o_rd_data (c_rd_data)
    );

    // Tile walker
    tmm_walk u_walk (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (walk_ctl),
        .i_n     (size_n),
        .o_pos   (walk_pos)
    );

    // Controller: next state and memory strobes
    always_comb begin
        n_state       = r_state;
        walk_ctl      = '0;
        ab_rd_en      = 1'b0;
        c_wr_en       = 1'b0;
        c_wr_addr     = cell_addr(32'(walk_pos.i), 32'(walk_pos.j));
        c_wr_data     = c_rd_data + r_prod;
        c_rd_en       = 1'b0;
        c_rd_addr     = cell_addr(32'(walk_pos.i), 32'(walk_pos.j));
        out_load      = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                c_rd_addr = in_addr;
                if (accept) begin
                    unique case (i_in.opcode)
                        OP_RUN: n_state = S_CLEAR;
                        OP_READ: begin
                            c_rd_en = 1'b1;
                            n_state = S_READ;
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_READ: begin
                if (out_free) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            S_CLEAR: begin
                c_wr_en   = 1'b1;
                c_wr_addr = r_clr;
                c_wr_data = '0;
                if (r_clr == CLR_LAST) begin
                    if (size_n == '0) begin
                        n_state = S_DONE;
                    end else begin
                        walk_ctl.start = 1'b1;
                        n_state        = S_ISSUE;
                    end
                end
            end
            S_ISSUE: begin
                ab_rd_en = 1'b1;
                c_rd_en  = 1'b1;
                n_state  = S_MUL;
            end
            S_MUL: begin
                n_state = S_ACC;
            end
            S_ACC: begin
                c_wr_en = 1'b1;
                if (walk_pos.last) begin
                    n_state = S_DONE;
                end else begin
                    walk_ctl.step = 1'b1;
                    n_state       = S_ISSUE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State, size, clear counter and blank flag of C
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_size    <= SIZE_RESET;
            r_clr     <= '0;
            r_c_blank <= 1'b1;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                r_size <= i_cfg_wr_data;
            end
            if (r_state == S_CLEAR) begin
                r_clr     <= r_clr + ADDR_W'(1);
                r_c_blank <= 1'b0;
            end else begin
                r_clr <= '0;
            end
        end
    end

    // Product register and read request capture
    always_ff @(posedge i_clk) begin
        if (r_state == S_MUL) begin
            r_prod <= VAL_W'(a_rd_data * b_rd_data);
        end
        if (accept) begin
            r_rd_row    <= i_in.row_index;
            r_rd_col    <= i_in.col_index;
            r_rd_inside <= in_inside;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            if (r_state == S_READ) begin
                r_out_kind  <= RK_READ;
                r_out_row   <= r_rd_row;
                r_out_col   <= r_rd_col;
                r_out_value <= (r_rd_inside && !r_c_blank) ? c_rd_data : '0;
            end else begin
                r_out_kind  <= RK_DONE;
                r_out_row   <= '0;
                r_out_col   <= '0;
                r_out_value <= '0;
            end
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.result_kind   = r_out_kind;
    assign o_out.out_row       = r_out_row;
    assign o_out.out_col       = r_out_col;
    assign o_out.product_value = r_out_value;

`ifndef SYNTHESIS
    // C is only written by the clear sweep and the accumulate step
    a_c_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        c_wr_en |-> (r_state == S_CLEAR || r_state == S_ACC))
        else $error("C written outside a run");

    // A run request starts with the clear sweep
    a_run_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_in.opcode == OP_RUN) |=> (r_state == S_CLEAR && r_clr == '0))
        else $error("run did not start with a clear");

    // The last product leads straight to the done result
    a_last_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ACC && walk_pos.last) |=> r_state == S_DONE)
        else $error("run did not finish after last product");

    // A done result carries zero row, column and value
    a_done_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.result_kind == RK_DONE)
            |-> (o_out.out_row == '0 && o_out.out_col == '0
                 && o_out.product_value == '0))
        else $error("done result payload not zero");
`endif

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for tiled_matrix_multiply
// A short table of directed requests covers reset contents, the smallest sizes
// and the wrapping extremes of the multiply. It is followed by random phases
// at small sizes. Every request is mirrored in a local copy of A, B and C.
// The reply stream is compared field by field against the replies due.
// Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb;
    import tmm_pkg::*;

    localparam int RAND_ITEMS = 1030;
    localparam int DRAIN_CYC  = 8;

    // Expected reply on the output channel
    typedef struct {
        logic               kind;
        logic [ROW_W-1:0]   row;
        logic [COL_W-1:0]   col;
        logic [VAL_W-1:0]   value;
    } t_reply;

    // One row of the directed request table
    typedef struct {
        bit                 set_size;
        logic [SIZE_W-1:0]  size;
        t_opcode            op;
        logic [ROW_W-1:0]   row;
        logic [COL_W-1:0]   col;
        logic [VAL_W-1:0]   value;
        bit                 typed;
        logic [VAL_W-1:0]   want;
    } t_plan_row;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_wr_en;
    logic [SIZE_W-1:0] i_cfg_wr_data;

    tmm_in_if  in_ch ();
    tmm_out_if out_ch ();

    tiled_matrix_multiply dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in          (in_ch),
        .o_out         (out_ch)
    );

    always #5 i_clk = ~i_clk;

    // Local copy of the block's stores and size register
    logic [VAL_W-1:0]  a_mem [STORE_WORDS];
    logic [VAL_W-1:0]  b_mem [STORE_WORDS];
    logic [VAL_W-1:0]  c_mem [STORE_WORDS];
    bit                a_written [STORE_WORDS];
    bit                b_written [STORE_WORDS];
    logic [SIZE_W-1:0] cur_size;

    t_reply   replies_due [$];
    int       fail_count = 0;
    int       n_items    = 0;
    int       n_loads    = 0;
    int       n_runs     = 0;
    int       n_reads    = 0;
    int       n_sizes    = 0;
    bit       no_idle    = 1'b0;
    int       stall_left = 0;

    // Directed requests; expected values typed only where obvious
    t_plan_row plan [20] = '{
        // C reads back zero after reset
        '{1'b0, 6'd0,  OP_READ,   5'd0,  5'd0,  32'h0,        1'b1, 32'h0},
        '{1'b0, 6'd0,  OP_READ,   5'd31, 5'd31, 32'h0,        1'b1, 32'h0},
        // size zero: the run only clears C
        '{1'b1, 6'd0,  OP_RUN,    5'd0,  5'd0,  32'h0,        1'b1, 32'h0},
        '{1'b0, 6'd0,  OP_READ,   5'd2,  5'd3,  32'h0,        1'b1, 32'h0},
        // 1x1: max * max wraps to one
        '{1'b1, 6'd1,  OP_LOAD_A, 5'd0,  5'd0,  32'h7fffffff, 1'b0, 32'h0},
        '{1'b0, 6'd0,  OP_LOAD_B, 5'd0,  5'd0,  32'h7fffffff, 1'b0, 32'h0},
        '{1'b0, 6'd0,  OP_RUN,    5'd0,  5'd0,  32'h0,        1'b1, 32'h0},
        '{1'b0, 6'd0,  OP_READ,   5'd0,  5'd0,  32'h0,        1'b1, 32'h1},
        // min * min wraps to zero
        '{1'b0, 6'd0,  OP_LOAD_A, 5'd0,  5'd0,  32'h80000000, 1'b0, 32'h0},
        '{1'b0, 6'd0,  OP_LOAD_B, 5'd0,  5'd0,  32'h80000000, 1'b0, 32'h0},
        '{1'b0, 6'd0,  OP_RUN,    5'd0,  5'd0,  32'h0,        1'b1, 32'h0},
        '{1'b0, 6'd0,  OP_READ,   5'd0,  5'd0,  32'h0,        1'b1, 32'h0},
        // -1 * min
        '{1'b0, 6'd0,  OP_LOAD_A, 5'd0,  5'd0,  32'hffffffff, 1'b0, 32'h0},
        '{1'b0, 6'd0,  OP_RUN,    5'd0,  5'd0,  32'h0,        1'b0, 32'h0},
        '{1'b0, 6'd0,  OP_READ,   5'd0,  5'd0,  32'h0,        1'b0, 32'h0},
        // loads outside n; C outside n is zero after a run
        '{1'b0, 6'd0,  OP_LOAD_A, 5'd31, 5'd31, 32'h12345678, 1'b0, 32'h0},
        '{1'b0, 6'd0,  OP_LOAD_B, 5'd31, 5'd31, 32'hdeadbeef, 1'b0, 32'h0},
        '{1'b0, 6'd0,  OP_RUN,    5'd0,  5'd0,  32'h0,        1'b1, 32'h0},
        '{1'b0, 6'd0,  OP_READ,   5'd31, 5'd31, 32'h0,        1'b1, 32'h0},
        '{1'b0, 6'd0,  OP_READ,   5'd0,  5'd31, 32'h0,        1'b1, 32'h0}
    };

    // Rows and columns actually in use
    function automatic int eff_size();
        return (cur_size > MAX_N) ? MAX_N : int'(cur_size);
    endfunction

    // Clear C, then accumulate A x B tile by tile with 32-bit wrap
    function automatic void multiply_stores();
        int n;
        int ci;
        n = eff_size();
        foreach (c_mem[x]) c_mem[x] = '0;
        for (int ii = 0; ii < n; ii += TILE)
            for (int kk = 0; kk < n; kk += TILE)
                for (int jj = 0; jj < n; jj += TILE)
                    for (int i = ii; i < ii + TILE && i < n; i++)
                        for (int k = kk; k < kk + TILE && k < n; k++)
                            for (int j = jj; j < jj + TILE && j < n; j++) begin
                                ci = i * MAX_N + j;
                                c_mem[ci] = c_mem[ci]
                                    + a_mem[i * MAX_N + k] * b_mem[k * MAX_N + j];
                            end
    endfunction

    // Apply one request to the local stores; returns 1 when it causes a reply
    function automatic bit reply_for(input t_opcode op, input logic [ROW_W-1:0] r,
                                     input logic [COL_W-1:0] c, input logic [VAL_W-1:0] v,
                                     output t_reply rep);
        int addr;
        addr = int'(r) * MAX_N + int'(c);
        rep = '{RK_DONE, '0, '0, '0};
        case (op)
            OP_LOAD_A: begin
                a_mem[addr] = v;
                a_written[addr] = 1'b1;
                return 1'b0;
            end
            OP_LOAD_B: begin
                b_mem[addr] = v;
                b_written[addr] = 1'b1;
                return 1'b0;
            end
            OP_RUN: begin
                multiply_stores();
                return 1'b1;
            end
            default: begin
                rep = '{RK_READ, r, c, c_mem[addr]};
                return 1'b1;
            end
        endcase
    endfunction

    // Mostly full-range words, some extremes and some small values
    function automatic logic [VAL_W-1:0] rand_word();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
            case ($urandom_range(0, 4))
                0: return 32'h0;
                1: return 32'h1;
                2: return 32'hffffffff;
                3: return 32'h7fffffff;
                default: return 32'h80000000;
            endcase
        end
        if (pick < 30) return VAL_W'($signed($urandom_range(0, 16)) - 8);
        return $urandom;
    endfunction

    // Random gap after a request, unless the phase runs without idling
    task automatic idle_gap();
        int gap;
        int pick;
        gap = 0;
        pick = $urandom_range(0, 99);
        if (!no_idle) begin
            if (pick < 5) gap = $urandom_range(8, 30);
            else if (pick < 30) gap = $urandom_range(1, 3);
        end
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Send one request, wait for it to be taken, queue its reply
    task automatic issue_req(input t_opcode op, input logic [ROW_W-1:0] r,
                             input logic [COL_W-1:0] c, input logic [VAL_W-1:0] v,
                             input bit typed, input logic [VAL_W-1:0] want);
        t_reply   rep;
        bit       has_rep;
        in_ch.valid         <= 1'b1;
        in_ch.opcode        <= op;
        in_ch.row_index     <= r;
        in_ch.col_index     <= c;
        in_ch.element_value <= v;
        do @(posedge i_clk); while (!in_ch.ready);
        has_rep = reply_for(op, r, c, v, rep);
        if (typed) begin
            if (op == OP_RUN) rep = '{RK_DONE, '0, '0, '0};
            else rep = '{RK_READ, r, c, want};
        end
        if (has_rep) replies_due.push_back(rep);
        n_items++;
        case (op)
            OP_RUN:  n_runs++;
            OP_READ: n_reads++;
            default: n_loads++;
        endcase
        idle_gap();
    endtask

    // Let the block go idle, then write the size register
    task automatic set_size(input logic [SIZE_W-1:0] size);
        in_ch.valid <= 1'b0;
        while (replies_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= size;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        cur_size = size;
        n_sizes++;
    endtask

    // Load every A and B element a run of the current size will use
    task automatic fill_missing();
        int n;
        n = eff_size();
        for (int r = 0; r < n; r++)
            for (int c = 0; c < n; c++) begin
                if (!a_written[r * MAX_N + c])
                    issue_req(OP_LOAD_A, ROW_W'(r), COL_W'(c), rand_word(), 1'b0, '0);
                if (!b_written[r * MAX_N + c])
                    issue_req(OP_LOAD_B, ROW_W'(r), COL_W'(c), rand_word(), 1'b0, '0);
            end
    endtask

    task automatic safe_run();
        fill_missing();
        issue_req(OP_RUN, '0, '0, rand_word(), 1'b0, '0);
    endtask

    // Row or column: mostly inside n, sometimes anywhere in the store
    function automatic logic [ROW_W-1:0] pick_index(input int n);
        if (n > 0 && $urandom_range(0, 9) < 7) return ROW_W'($urandom_range(0, n - 1));
        return ROW_W'($urandom_range(0, MAX_N - 1));
    endfunction

    // Random phase: loads, runs and reads at one size
    task automatic random_phase(input int start_items, input int budget);
        int pick;
        int n;
        int issued;
        n = eff_size();
        issued = 0;
        no_idle = ($urandom_range(0, 3) == 0);
        while (issued < budget && n_items - start_items < RAND_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 28)
                issue_req(OP_LOAD_A, pick_index(n), pick_index(n), rand_word(), 1'b0, '0);
            else if (pick < 56)
                issue_req(OP_LOAD_B, pick_index(n), pick_index(n), rand_word(), 1'b0, '0);
            else if (pick < 62)
                safe_run();
            else
                issue_req(OP_READ, pick_index(n), pick_index(n), rand_word(), 1'b0, '0);
            issued++;
        end
        no_idle = 1'b0;
    endtask

    // Reply side: random stalls, mostly short, a few long
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            out_ch.ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end else if (!no_idle && $urandom_range(0, 99) < 12) begin
            out_ch.ready <= 1'b0;
            stall_left   <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
                                                        : $urandom_range(0, 2);
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    // Reply checker
    always @(posedge i_clk) begin : check_replies
        t_reply due;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (replies_due.size() == 0) begin
                $error("unexpected reply: kind %0d row %0d col %0d value %h",
                       out_ch.result_kind, out_ch.out_row, out_ch.out_col,
                       out_ch.product_value);
                fail_count++;
            end else begin
                due = replies_due.pop_front();
                if (out_ch.result_kind !== due.kind) begin
                    $error("result_kind: expected %0d, got %0d", due.kind, out_ch.result_kind);
                    fail_count++;
                end
                if (out_ch.out_row !== due.row) begin
                    $error("out_row: expected %0d, got %0d", due.row, out_ch.out_row);
                    fail_count++;
                end
                if (out_ch.out_col !== due.col) begin
                    $error("out_col: expected %0d, got %0d", due.col, out_ch.out_col);
                    fail_count++;
                end
                if (out_ch.product_value !== due.value) begin
                    $error("product_value: expected %h, got %h", due.value,
                           out_ch.product_value);
                    fail_count++;
                end
            end
        end
    end

    // Stimulus
    initial begin
        int rand_start;
        int sz;
        int pick;
        i_rst_n             <= 1'b0;
        i_cfg_wr_en         <= 1'b0;
        i_cfg_wr_data       <= '0;
        in_ch.valid         <= 1'b0;
        in_ch.opcode        <= OP_LOAD_A;
        in_ch.row_index     <= '0;
        in_ch.col_index     <= '0;
        in_ch.element_value <= '0;
        foreach (c_mem[x]) begin
            a_mem[x] = '0;
            b_mem[x] = '0;
            c_mem[x] = '0;
            a_written[x] = 1'b0;
            b_written[x] = 1'b0;
        end
        cur_size = SIZE_RESET;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table
        foreach (plan[p]) begin
            if (plan[p].set_size) set_size(plan[p].size);
            issue_req(plan[p].op, plan[p].row, plan[p].col, plan[p].value,
                      plan[p].typed, plan[p].want);
        end

        // Random phases at small sizes
        rand_start = n_items;
        while (n_items - rand_start < RAND_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 5) sz = 0;
            else if (pick < 50) sz = $urandom_range(1, 4);
            else if (pick < 95) sz = $urandom_range(5, 12);
            else sz = $urandom_range(13, 20);
            set_size(SIZE_W'(sz));
            random_phase(rand_start, $urandom_range(15, 60));
        end

        // Drain and finish
        in_ch.valid <= 1'b0;
        while (replies_due.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        $display("Covered %0d requests: %0d loads, %0d runs, %0d reads", n_items, n_loads,
                 n_runs, n_reads);
        $display("Size register written %0d times, sizes 0 to 20", n_sizes);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Watchdog: a run clears all 1024 words of C, then reads, multiplies and
    // writes back one C word per product, the most at size 20; some hundred runs
    // plus loads, reads, gaps and stalls must end well before the time-out below
    initial begin
        #100_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
